[hw/rtl/utf8d_pkg.sv]
package utf8d_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned STAT_W  = 2;

  localparam logic [STATE_W-1:0] ST_ACCEPT = 4'h0;
  localparam logic [STATE_W-1:0] ST_REJECT = 4'hF;

  localparam logic [STAT_W-1:0] STAT_CODE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TRUNCATED = 2'd2;

  localparam logic [31:0] CLASS_TAB [16] = '{
    32'h88888888, 32'h88888888, 32'h99999999, 32'h99999999,
    32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa,
    32'h222222ff, 32'h22222222, 32'h22222222, 32'h22222222,
    32'h3333333b, 32'h33433333, 32'hfff5666c, 32'hffffffff
  };

  localparam logic [31:0] NEXT_TAB [16] = '{
    32'hfffffff0, 32'hffffffff, 32'hfffffff1, 32'hfffffff3,
    32'hfffffff4, 32'hfffffff7, 32'hfffffff6, 32'hffffffff,
    32'h33f11f0f, 32'hf3311f0f, 32'hf33f110f, 32'hfffffff2,
    32'hfffffff5, 32'hffffffff, 32'hffffffff, 32'hffffffff
  };

  typedef struct packed {
    logic               emit;
    logic [CP_W-1:0]    code_point;
    logic [STAT_W-1:0]  status;
    logic [STATE_W-1:0] state;
    logic [CP_W-1:0]    partial;
  } step_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [31:0] row;
    row = CLASS_TAB[b[6:3]];
    if (!b[7]) begin
      return 4'h0;
    end
    return row[{b[2:0], 2'b00} +: 4];
  endfunction

  function automatic logic [STATE_W-1:0] next_state(input logic [3:0] cls,
                                                    input logic [STATE_W-1:0] st);
    logic [31:0] row;
    row = NEXT_TAB[cls];
    if (st[3]) begin
      return ST_REJECT;
    end
    return row[{st[2:0], 2'b00} +: 4];
  endfunction

endpackage

[hw/rtl/utf8d_step.sv]
module utf8d_step (
  input  logic [7:0]                      octet,
  input  logic                            string_end,
  input  logic [utf8d_pkg::STATE_W-1:0]   state,
  input  logic [utf8d_pkg::CP_W-1:0]      partial,
  output utf8d_pkg::step_t                step
);

  logic [3:0]                    cls;
  logic [utf8d_pkg::STATE_W-1:0] nxt;
  logic [utf8d_pkg::CP_W-1:0]    gathered;
  logic [7:0]                    lead_mask;

  assign cls       = utf8d_pkg::byte_class(octet);
  assign nxt       = utf8d_pkg::next_state(cls, state);
  assign lead_mask = 8'hFF >> cls;

  always_comb begin
    if (state == utf8d_pkg::ST_ACCEPT) begin
      gathered = {13'd0, octet & lead_mask};
    end else begin
      gathered = {partial[14:0], octet[5:0]};
    end
  end

  always_comb begin
    step.emit       = 1'b1;
    step.code_point = '0;
    step.status     = utf8d_pkg::STAT_CODE;
    step.state      = utf8d_pkg::ST_ACCEPT;
    step.partial    = '0;
    priority if (nxt == utf8d_pkg::ST_ACCEPT) begin
      step.code_point = gathered;
      step.partial    = gathered;
    end else if (nxt == utf8d_pkg::ST_REJECT) begin
      step.status = utf8d_pkg::STAT_INVALID;
    end else if (string_end) begin
      step.status = utf8d_pkg::STAT_TRUNCATED;
    end else begin
      step.emit    = 1'b0;
      step.state   = nxt;
      step.partial = gathered;
    end
  end

endmodule

[hw/rtl/utf8_stream_decoder.sv]
// UTF-8 stream decoder: takes one byte per transaction and returns at most one
// result per byte: a code point when a sequence completes, an invalid-byte
// status when a byte is rejected (the byte is dropped, no sequence restarts
// from it), or a truncation status when a byte marked as string end leaves a
// sequence open. Overlong forms, surrogates and values above U+10FFFF are
// rejected. A byte lands in an input register and passes one table-lookup step
// into the result register once that register is free (empty or being read),
// so each result is presented from a register, and the block sustains one byte
// per clock while the result side keeps up.
module utf8_stream_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_octet,
  input  logic                          in_string_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utf8d_pkg::CP_W-1:0]    out_code_point,
  output logic [utf8d_pkg::STAT_W-1:0]  out_status,
  output logic                          out_last_of_string
);

  logic                          s1_valid_r;
  logic [7:0]                    s1_octet_r;
  logic                          s1_end_r;
  logic [utf8d_pkg::STATE_W-1:0] state_r;
  logic [utf8d_pkg::CP_W-1:0]    partial_r;
  logic                          out_valid_r;
  logic [utf8d_pkg::CP_W-1:0]    out_cp_r;
  logic [utf8d_pkg::STAT_W-1:0]  out_status_r;
  logic                          out_last_r;
  logic                          out_free;
  logic                          s1_fire;
  utf8d_pkg::step_t              step;

  utf8d_step u_step (
    .octet      (s1_octet_r),
    .string_end (s1_end_r),
    .state      (state_r),
    .partial    (partial_r),
    .step       (step)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_octet_r <= in_octet;
      s1_end_r   <= in_string_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= utf8d_pkg::ST_ACCEPT;
      partial_r <= '0;
    end else if (s1_fire) begin
      state_r   <= step.state;
      partial_r <= step.partial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= step.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step.emit) begin
      out_cp_r     <= step.code_point;
      out_status_r <= step.status;
      out_last_r   <= s1_end_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_point     = out_cp_r;
  assign out_status         = out_status_r;
  assign out_last_of_string = out_last_r;

  a_state_reachable: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r[3])
    else $error("decoder state left the reachable range");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == utf8d_pkg::STAT_CODE ||
                     out_status_r == utf8d_pkg::STAT_INVALID ||
                     out_status_r == utf8d_pkg::STAT_TRUNCATED))
    else $error("illegal result status");

  a_error_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != utf8d_pkg::STAT_CODE) |-> out_cp_r == '0)
    else $error("error result carries a code point");

  a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == utf8d_pkg::STAT_TRUNCATED) |-> out_last_r)
    else $error("truncation reported away from string end");

  a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_end_r || step.status != utf8d_pkg::STAT_CODE))
      |=> state_r == utf8d_pkg::ST_ACCEPT)
    else $error("state not back to accept after error or string end");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam logic [31:0] LEAD_CLASS_ROWS [16] = '{
    32'h88888888, 32'h88888888, 32'h99999999, 32'h99999999,
    32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa,
    32'h222222ff, 32'h22222222, 32'h22222222, 32'h22222222,
    32'h3333333b, 32'h33433333, 32'hfff5666c, 32'hffffffff
  };

  localparam logic [31:0] TRANSITION_ROWS [16] = '{
    32'hfffffff0, 32'hffffffff, 32'hfffffff1, 32'hfffffff3,
    32'hfffffff4, 32'hfffffff7, 32'hfffffff6, 32'hffffffff,
    32'h33f11f0f, 32'hf3311f0f, 32'hf33f110f, 32'hfffffff2,
    32'hfffffff5, 32'hffffffff, 32'hffffffff, 32'hffffffff
  };

  typedef struct packed {
    logic [utf8d_pkg::CP_W-1:0]   code_point;
    logic [utf8d_pkg::STAT_W-1:0] status;
    logic                         last_of_string;
  } decode_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_octet = 8'h00;
  logic                           in_string_end = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [utf8d_pkg::CP_W-1:0]     out_code_point;
  logic [utf8d_pkg::STAT_W-1:0]   out_status;
  logic                           out_last_of_string;

  logic [utf8d_pkg::STATE_W-1:0]  dec_state = utf8d_pkg::ST_ACCEPT;
  logic [utf8d_pkg::CP_W-1:0]     dec_partial = '0;
  decode_result_t                 pending_results [$];
  logic [7:0]                     seq_bytes [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int n_sent = 0;
  int n_codes = 0;
  int n_invalid = 0;
  int n_trunc = 0;
  int n_bad = 0;
  int stall_cycles = 0;

  utf8_stream_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_octet          (in_octet),
    .in_string_end     (in_string_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_point    (out_code_point),
    .out_status        (out_status),
    .out_last_of_string(out_last_of_string)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic queue_byte(input logic [7:0] b);
    seq_bytes.insert(seq_bytes.size(), b);
  endtask

  task automatic queue_result(input decode_result_t res);
    pending_results.insert(pending_results.size(), res);
  endtask

  task automatic decode_octet(input logic [7:0] b, input logic fin);
    logic [31:0]                   row;
    logic [3:0]                    cls;
    logic [utf8d_pkg::STATE_W-1:0] nxt;
    decode_result_t                res;
    row = LEAD_CLASS_ROWS[b[6:3]];
    cls = b[7] ? row[4*b[2:0] +: 4] : 4'h0;
    if (dec_state == utf8d_pkg::ST_ACCEPT) begin
      dec_partial = utf8d_pkg::CP_W'(b & (8'hFF >> cls));
    end else begin
      dec_partial = {dec_partial[utf8d_pkg::CP_W-7:0], b[5:0]};
    end
    row = TRANSITION_ROWS[cls];
    nxt = dec_state[3] ? utf8d_pkg::ST_REJECT : row[4*dec_state[2:0] +: 4];
    res.last_of_string = fin;
    if (nxt == utf8d_pkg::ST_ACCEPT) begin
      res.code_point = dec_partial;
      res.status = utf8d_pkg::STAT_CODE;
      queue_result(res);
      dec_state = utf8d_pkg::ST_ACCEPT;
    end else if (nxt == utf8d_pkg::ST_REJECT || fin) begin
      res.code_point = '0;
      res.status = (nxt == utf8d_pkg::ST_REJECT) ? utf8d_pkg::STAT_INVALID :
                                                   utf8d_pkg::STAT_TRUNCATED;
      queue_result(res);
      dec_state = utf8d_pkg::ST_ACCEPT;
      dec_partial = '0;
    end else begin
      dec_state = nxt;
    end
  endtask

  task automatic push_octet(input logic [7:0] b, input logic fin);
    @(negedge clk);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_octet <= b;
    in_string_end <= fin;
    do @(posedge clk); while (!in_ready);
    decode_octet(b, fin);
    n_sent++;
  endtask

  task automatic hold_input_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic flush_burst(input bit end_last);
    foreach (seq_bytes[i]) begin
      push_octet(seq_bytes[i], end_last && (i == seq_bytes.size() - 1));
    end
    seq_bytes.delete();
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [utf8d_pkg::CP_W-1:0] random_scalar(input int unsigned min_len);
    int unsigned cp;
    case ($urandom_range(min_len - 1, 3))
      0: cp = $urandom_range(0, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: begin
        cp = $urandom_range('h800, 'hFFFF);
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp - 'h800;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return utf8d_pkg::CP_W'(cp);
  endfunction

  task automatic encode_scalar(input logic [utf8d_pkg::CP_W-1:0] cp);
    if (cp < 'h80) begin
      queue_byte(cp[7:0]);
    end else if (cp < 'h800) begin
      queue_byte({3'b110, cp[10:6]});
      queue_byte({2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      queue_byte({4'b1110, cp[15:12]});
      queue_byte({2'b10, cp[11:6]});
      queue_byte({2'b10, cp[5:0]});
    end else begin
      queue_byte({5'b11110, cp[20:18]});
      queue_byte({2'b10, cp[17:12]});
      queue_byte({2'b10, cp[11:6]});
      queue_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic build_malformed();
    case ($urandom_range(0, 7))
      0: begin
        queue_byte(8'($urandom_range('hC0, 'hC1)));
        queue_byte(cont_byte());
      end
      1: begin
        queue_byte(8'hE0);
        queue_byte(8'($urandom_range('h80, 'h9F)));
        queue_byte(cont_byte());
      end
      2: begin
        queue_byte(8'hF0);
        queue_byte(8'($urandom_range('h80, 'h8F)));
        queue_byte(cont_byte());
        queue_byte(cont_byte());
      end
      3: begin
        queue_byte(8'hED);
        queue_byte(8'($urandom_range('hA0, 'hBF)));
        queue_byte(cont_byte());
      end
      4: begin
        queue_byte(8'hF4);
        queue_byte(8'($urandom_range('h90, 'hBF)));
        queue_byte(cont_byte());
        queue_byte(cont_byte());
      end
      5: begin
        queue_byte(8'($urandom_range('hF5, 'hFF)));
        queue_byte(cont_byte());
      end
      6: begin
        encode_scalar(random_scalar(2));
        seq_bytes = seq_bytes[0:0];
        if ($urandom_range(0, 1)) begin
          queue_byte(8'($urandom_range(0, 'h7F)));
        end else begin
          queue_byte(8'($urandom_range('hC2, 'hF4)));
        end
      end
      default: begin
        repeat ($urandom_range(1, 3)) queue_byte(cont_byte());
      end
    endcase
  endtask

  task automatic test_valid_forms();
    push_octet(8'h00, 1'b1);
    push_octet(8'h7F, 1'b0);
    push_octet(8'hC2, 1'b0);
    push_octet(8'h80, 1'b0);
    push_octet(8'hE0, 1'b0);
    push_octet(8'hA0, 1'b0);
    push_octet(8'h80, 1'b0);
    push_octet(8'hEF, 1'b0);
    push_octet(8'hBF, 1'b0);
    push_octet(8'hBF, 1'b1);
    push_octet(8'hF4, 1'b0);
    push_octet(8'h8F, 1'b0);
    push_octet(8'hBF, 1'b0);
    push_octet(8'hBF, 1'b0);
  endtask

  task automatic test_rejected_forms();
    push_octet(8'hC0, 1'b0);
    push_octet(8'hFF, 1'b1);
    push_octet(8'hE0, 1'b0);
    push_octet(8'h80, 1'b0);
    push_octet(8'hED, 1'b0);
    push_octet(8'hA0, 1'b0);
    push_octet(8'hF4, 1'b0);
    push_octet(8'h90, 1'b0);
    push_octet(8'h80, 1'b0);
    push_octet(8'hE2, 1'b0);
    push_octet(8'h82, 1'b1);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int start;
    int pick;
    start = n_sent;
    while (n_sent - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        encode_scalar(random_scalar(1));
        flush_burst($urandom_range(0, 5) == 0);
      end else if (pick < 80) begin
        push_octet(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (pick < 88) begin
        encode_scalar(random_scalar(2));
        repeat ($urandom_range(1, seq_bytes.size() - 1)) void'(seq_bytes.pop_back());
        flush_burst(1'b1);
      end else begin
        build_malformed();
        flush_burst($urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_left = 80;
    repeat (20) begin
      encode_scalar(random_scalar(1));
      flush_burst($urandom_range(0, 5) == 0);
    end
    hold_input_until_drained();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    decode_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("unexpected result: cp=%h status=%0d last=%0b",
                   out_code_point, out_status, out_last_of_string);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_code_point !== want.code_point || out_status !== want.status ||
            out_last_of_string !== want.last_of_string) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch: expected cp=%h status=%0d last=%0b",
                     want.code_point, want.status, want.last_of_string);
            $display("          got cp=%h status=%0d last=%0b",
                     out_code_point, out_status, out_last_of_string);
          end
        end
        case (want.status)
          utf8d_pkg::STAT_CODE:    n_codes++;
          utf8d_pkg::STAT_INVALID: n_invalid++;
          default:                 n_trunc++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 pending_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 28;
    rx_idle_pct = 48;
    test_valid_forms();
    test_rejected_forms();
    hold_input_until_drained();
    test_random_traffic(220);
    test_backpressure();

    tx_idle_pct = 48;
    rx_idle_pct = 28;
    test_random_traffic(220);
    hold_input_until_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(220);

    hold_input_until_drained();
    repeat (8) @(posedge clk);

    $display("Decoded %0d bytes into %0d code points, %0d invalid-byte results",
             n_sent, n_codes, n_invalid);
    $display("and %0d truncation results; covered valid, overlong, surrogate,",
             n_trunc);
    $display("out-of-range and cut-off sequences under stalls");
    if (n_bad == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_step.sv
hw/rtl/utf8_stream_decoder.sv
tb/sv/tb_top.sv
